FILE: design/tsmcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-state min-cost path: shared package
// Widths, the column item held in the queue between front and back, and
// the queue head bundle.
// ----------------------------------------------------------------------------
package tsmcp_pkg;

   localparam int VALUE_BITS = 16;
   localparam int COST_BITS  = 40;
   localparam int ROWS       = 3;

   // |a - b| of two VALUE_BITS signed values needs one more bit
   localparam int DIFF_W = VALUE_BITS + 1;
   // candidate sum, wide enough to see any overflow past the cost maximum
   localparam int SUM_W  = ((COST_BITS > DIFF_W) ? COST_BITS : DIFF_W) + 1;

   localparam int REQ_TDATA_W = ((ROWS * VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((COST_BITS + 7) / 8) * 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COST_BITS-1:0] COST_MAX = '1;

   typedef struct packed {
      logic                             first_column;
      logic                             last_column;
      logic [ROWS-1:0][VALUE_BITS-1:0]  values;
   } column_type;

   typedef struct packed {
      logic       valid;
      column_type item;
   } queue_head_type;

endpackage

FILE: design/tsmcp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-state min-cost path: front end
// Accepts columns, tags the first column of each sequence and holds them
// in a short queue for the back end.
// ----------------------------------------------------------------------------
module tsmcp_front
   import tsmcp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   output queue_head_type         head,
   input  logic                   pop
);

   column_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              started_ff;
   logic              push;
   column_type        item_in;

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;

   always_comb begin
      item_in.first_column = !started_ff;
      item_in.last_column  = req_tlast;
      item_in.values       = req_tdata[ROWS*VALUE_BITS-1:0];
   end

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         started_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff  <= wr_ptr_ff + QPTR_W'(1);
            started_ff <= !req_tlast;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

   // never pops an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty column queue");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count did not follow a push");

   // a column after the last one opens a new sequence
   assert property (@(posedge clock) disable iff (reset)
      (push && req_tlast) |=> !started_ff)
      else $error("sequence not closed after last column");

endmodule

FILE: design/tsmcp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-state min-cost path: back end
// Add-compare-select over three states per column, then a final minimum
// and the result register.
// ----------------------------------------------------------------------------
module tsmcp_back
   import tsmcp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  queue_head_type         head,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   logic [ROWS-1:0][VALUE_BITS-1:0] prev_ff;
   logic [ROWS-1:0][COST_BITS-1:0]  cost_ff;
   logic [ROWS-1:0][COST_BITS-1:0]  cost_in;
   logic                            sat_ff;
   logic                            sat_in;

   logic                            fin_valid_ff;
   logic [ROWS-1:0][COST_BITS-1:0]  fin_cost_ff;
   logic                            fin_sat_ff;
   logic                            fin_move;

   logic                            rsp_valid_ff;
   logic [COST_BITS-1:0]            rsp_cost_ff;
   logic [COST_BITS-1:0]            rsp_cost_in;
   logic                            rsp_sat_ff;

   function automatic logic [DIFF_W-1:0] abs_diff(input logic [VALUE_BITS-1:0] a,
                                                 input logic [VALUE_BITS-1:0] b);
      logic signed [VALUE_BITS:0] ea;
      logic signed [VALUE_BITS:0] eb;
      ea = signed'({a[VALUE_BITS-1], a});
      eb = signed'({b[VALUE_BITS-1], b});
      return (ea >= eb) ? DIFF_W'(ea - eb) : DIFF_W'(eb - ea);
   endfunction

   assign fin_move = fin_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign pop      = head.valid && (!fin_valid_ff || fin_move);

   // add-compare-select, nine candidates, one clamp flag per row
   always_comb begin
      logic [SUM_W-1:0]     sum;
      logic [COST_BITS-1:0] cand;
      logic [COST_BITS-1:0] best;
      logic                 all_clamped;
      sat_in = sat_ff;
      for (int r = 0; r < ROWS; r++) begin
         best        = COST_MAX;
         all_clamped = 1'b1;
         for (int p = 0; p < ROWS; p++) begin
            sum = SUM_W'(cost_ff[p])
                + SUM_W'(abs_diff(head.item.values[r], prev_ff[p]));
            if (sum > SUM_W'(COST_MAX)) begin
               cand = COST_MAX;
            end else begin
               cand        = sum[COST_BITS-1:0];
               all_clamped = 1'b0;
            end
            if (cand < best) begin
               best = cand;
            end
         end
         if (head.item.first_column) begin
            cost_in[r] = '0;
         end else begin
            cost_in[r] = best;
            if (all_clamped) begin
               sat_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_cost_in = fin_cost_ff[0];
      if (fin_cost_ff[1] < rsp_cost_in) begin
         rsp_cost_in = fin_cost_ff[1];
      end
      if (fin_cost_ff[2] < rsp_cost_in) begin
         rsp_cost_in = fin_cost_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         cost_ff      <= '0;
         sat_ff       <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            prev_ff <= head.item.values;
            if (head.item.last_column) begin
               cost_ff <= '0;
               sat_ff  <= 1'b0;
            end else begin
               cost_ff <= cost_in;
               sat_ff  <= sat_in;
            end
         end
         if (pop && head.item.last_column) begin
            fin_valid_ff <= 1'b1;
         end else if (fin_move) begin
            fin_valid_ff <= 1'b0;
         end
         if (fin_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.item.last_column) begin
         fin_cost_ff <= cost_in;
         fin_sat_ff  <= sat_in;
      end
      if (fin_move) begin
         rsp_cost_ff <= rsp_cost_in;
         rsp_sat_ff  <= fin_sat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_cost_ff);
   assign rsp_tuser  = rsp_sat_ff;

   assert property (@(posedge clock) disable iff (reset)
      (pop && head.item.last_column) |=> fin_valid_ff)
      else $error("last column did not reach the final stage");

   assert property (@(posedge clock) disable iff (reset)
      (pop && head.item.last_column) |=> (cost_ff == '0 && !sat_ff))
      else $error("path costs not cleared after last column");

   // the first column of a sequence never raises saturation
   assert property (@(posedge clock) disable iff (reset)
      (pop && head.item.first_column && !sat_ff) |-> !sat_in)
      else $error("saturation raised on a first column");

   assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !fin_move) |-> !pop)
      else $error("column taken while final stage blocked");

endmodule

FILE: design/three_state_min_cost_path_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-state min-cost path unit
// Trellis dynamic programming over columns of three signed values.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one column per item: three signed values in tdata and
//   the end-of-sequence mark in tlast. Each column updates three path
//   costs, cost(r) = min over p of cost(p) + |value(r) - previous(p)|; the
//   first column of a sequence sets all costs to zero.
//   rsp_* carries one item per sequence, after its last column: the
//   smallest of the three costs in tdata and a saturation flag in tuser.
//   Costs clamp at 2^40 - 1; the flag is set when some row's true minimum
//   went past that.
// Throughput: one column per cycle while the final stage is not held by a
//   stalled result. Path: the last column passes through the queue, the
//   compare-select into the final stage, then the final minimum into the
//   result register.
// Reset: clears the queue, the costs, the stored column and the result.
// Stall: a held result fills the final stage, then the four-item queue;
//   req_tready drops only when the queue is full.
// ----------------------------------------------------------------------------
module three_state_min_cost_path_unit
   import tsmcp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // value_row0 [15:0], value_row1 [31:16], value_row2 [47:32]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // last_column
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // min_cost [39:0]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // cost_saturated
   output logic                   rsp_tuser
);

   queue_head_type head;
   logic           pop;

   // front: accept, tag first column, queue
   tsmcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .head       (head),
      .pop        (pop)
   );

   // back: compare-select, final minimum, result register
   tsmcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: tb/tb_three_state_min_cost_path_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-state min-cost path unit: self-checking testbench
// Streams columns of three signed values into the unit and checks the
// minimum path cost and saturation flag given on each last column against
// an in-bench trellis predictor. A directed table of corner columns runs
// first, then about a thousand random columns in sequences of random
// length. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_three_state_min_cost_path_unit;
   import tsmcp_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_COLUMNS = 1030;
   localparam int IDLE_LIMIT     = 1000;  // cycles with no item moving on either side
   localparam int DRAIN_CYCLES   = 8;     // wait after the last expected result for any stray one
   localparam int REPORT_LIMIT   = 10;
   localparam int DIRECTED_ROWS  = 20;

   typedef logic [COST_BITS-1:0]             cost_type;
   typedef logic [ROWS-1:0][VALUE_BITS-1:0]  column_bits_type;   // row 0 in the low bits

   typedef struct {
      cost_type min_cost;
      bit       saturated;
   } path_total_type;

   // One column of the directed table. Where fixed is set, the total given
   // here is what the last column must produce; otherwise the predictor's.
   typedef struct {
      int       row0;
      int       row1;
      int       row2;
      bit       last;
      bit       fixed;
      cost_type min_cost;
      bit       saturated;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   three_state_min_cost_path_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Trellis predictor: its own copy of the kept column, costs and flags
   // ------------------------------------------------------------------------
   column_bits_type held_column;
   cost_type        path_cost [ROWS];
   bit              sequence_open;
   bit              clamp_seen;
   path_total_type  pending_totals [$];
   int              miss_count;

   // Advances the trellis by one column; returns 1 when the column closes a
   // sequence, with its total in best and flag.
   function automatic bit step_trellis(input column_bits_type col, input bit last,
                                       output cost_type best, output bit flag);
      cost_type                   next_cost [ROWS];
      logic signed [VALUE_BITS:0] cur_v;
      logic signed [VALUE_BITS:0] old_v;
      logic [VALUE_BITS:0]        span;
      logic [COST_BITS:0]         cand;
      logic [COST_BITS:0]         lowest;
      bit                         all_clamped;
      best = '0;
      flag = 1'b0;
      for (int r = 0; r < ROWS; r++) begin
         if (!sequence_open) begin
            // first column of a sequence: every row starts from nothing
            next_cost[r] = '0;
         end else begin
            lowest      = {1'b0, COST_MAX};
            all_clamped = 1'b1;
            for (int p = 0; p < ROWS; p++) begin
               cur_v = $signed(col[r]);
               old_v = $signed(held_column[p]);
               span  = (cur_v >= old_v) ? cur_v - old_v : old_v - cur_v;
               cand  = {1'b0, path_cost[p]} + span;
               if (cand > {1'b0, COST_MAX}) begin
                  cand = {1'b0, COST_MAX};
               end else begin
                  all_clamped = 1'b0;
               end
               if (cand < lowest) lowest = cand;
            end
            // only a row whose every candidate overflowed counts as clamped
            if (all_clamped) clamp_seen = 1'b1;
            next_cost[r] = lowest[COST_BITS-1:0];
         end
      end
      sequence_open = 1'b1;
      for (int r = 0; r < ROWS; r++) path_cost[r] = next_cost[r];
      held_column = col;
      if (!last) return 1'b0;
      best = path_cost[0];
      if (path_cost[1] < best) best = path_cost[1];
      if (path_cost[2] < best) best = path_cost[2];
      flag = clamp_seen;
      // the kept column survives; the next column overwrites it anyway
      for (int r = 0; r < ROWS; r++) path_cost[r] = '0;
      sequence_open = 1'b0;
      clamp_seen    = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_miss(input string what);
      miss_count++;
      if (miss_count <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // ------------------------------------------------------------------------
   // Idle draws: a random idle gap before each item, with calm stretches of no idling
   // ------------------------------------------------------------------------
   int source_left;
   bit source_calm;
   int sink_left;
   bit sink_calm;

   function automatic int next_gap(inout int left, inout bit calm);
      if (left == 0) begin
         calm = ($urandom_range(0, 3) == 0);
         left = $urandom_range(10, 60);
      end
      left--;
      return calm ? 0 : $urandom_range(0, 4);
   endfunction

   // Called at a rising edge; returns at the edge that accepts the column.
   // The valid is lowered only when a gap is drawn, so it is never dropped
   // and raised within the same step.
   task automatic send_column(input column_bits_type col, input bit last, input bit fixed,
                              input path_total_type given);
      int             gap;
      path_total_type want;
      gap = next_gap(source_left, source_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(col);
      req_tlast  <= last;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      if (step_trellis(col, last, want.min_cost, want.saturated)) begin
         pending_totals.push_back(fixed ? given : want);
      end
   endtask

   function automatic logic [VALUE_BITS-1:0] draw_value(input logic [VALUE_BITS-1:0] base);
      case ($urandom_range(0, 7))
         0:       return {1'b1, {(VALUE_BITS-1){1'b0}}};          // most negative
         1:       return {1'b0, {(VALUE_BITS-1){1'b1}}};          // most positive
         2, 3:    return base + VALUE_BITS'($urandom_range(0, 32)) - VALUE_BITS'(16);
         default: return VALUE_BITS'($urandom());
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Directed table: single columns, extreme swings, alternating bit
   // patterns, a row that holds steady, a repeated column.
   // Cost saturation needs far more columns than a run can afford (2^40 over
   // a 65535 step), so the flag is only ever expected low here.
   // ------------------------------------------------------------------------
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // single column straight after reset
      '{0,      0,      0,      1'b1, 1'b1, 40'd0,      1'b0},
      '{-32768, 32767,  -1,     1'b1, 1'b1, 40'd0,      1'b0},
      // full swing across every row, both directions
      '{-32768, -32768, -32768, 1'b0, 1'b0, 40'd0,      1'b0},
      '{32767,  32767,  32767,  1'b1, 1'b1, 40'd65535,  1'b0},
      '{32767,  32767,  32767,  1'b0, 1'b0, 40'd0,      1'b0},
      '{-32768, -32768, -32768, 1'b1, 1'b1, 40'd65535,  1'b0},
      // mixed small values
      '{100,    -200,   300,    1'b0, 1'b0, 40'd0,      1'b0},
      '{0,      0,      0,      1'b0, 1'b0, 40'd0,      1'b0},
      '{-5,     5,      -5,     1'b1, 1'b0, 40'd0,      1'b0},
      // alternating bit patterns in every row
      '{21845,  -21846, 21845,  1'b0, 1'b0, 40'd0,      1'b0},
      '{-21846, 21845,  -21846, 1'b1, 1'b0, 40'd0,      1'b0},
      // row 0 holds steady while the others swing: zero-cost path along it
      '{7,      -32768, 32767,  1'b0, 1'b0, 40'd0,      1'b0},
      '{7,      32767,  -32768, 1'b0, 1'b0, 40'd0,      1'b0},
      '{7,      0,      0,      1'b1, 1'b1, 40'd0,      1'b0},
      // two full swings in a row
      '{-32768, -32768, -32768, 1'b0, 1'b0, 40'd0,      1'b0},
      '{32767,  32767,  32767,  1'b0, 1'b0, 40'd0,      1'b0},
      '{-32768, -32768, -32768, 1'b1, 1'b1, 40'd131070, 1'b0},
      '{-1,     -1,     -1,     1'b1, 1'b1, 40'd0,      1'b0},
      // the same column twice costs nothing
      '{1,      -2,     3,      1'b0, 1'b0, 40'd0,      1'b0},
      '{1,      -2,     3,      1'b1, 1'b1, 40'd0,      1'b0}
   };

   // ------------------------------------------------------------------------
   // Column source: reset, directed table, random sequences, verdict
   // ------------------------------------------------------------------------
   initial begin : column_source
      column_bits_type       col;
      path_total_type        given;
      logic [VALUE_BITS-1:0] base;
      int                    sent;
      int                    seq_len;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      held_column   = '0;
      sequence_open = 1'b0;
      clamp_seen    = 1'b0;
      miss_count    = 0;
      source_left   = 0;
      source_calm   = 1'b0;
      for (int r = 0; r < ROWS; r++) path_cost[r] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         col[0] = VALUE_BITS'(directed_rows[i].row0);
         col[1] = VALUE_BITS'(directed_rows[i].row1);
         col[2] = VALUE_BITS'(directed_rows[i].row2);
         given.min_cost  = directed_rows[i].min_cost;
         given.saturated = directed_rows[i].saturated;
         send_column(col, directed_rows[i].last, directed_rows[i].fixed, given);
      end

      // Random sequences: mostly short, now and then a long one so costs
      // climb well past the 16-bit range. Values cluster around a base per
      // sequence some of the time, which keeps several rows competitive.
      given = '{default: '0};
      sent  = 0;
      while (sent < RANDOM_COLUMNS) begin
         seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64)
                                               : $urandom_range(1, 8);
         base    = VALUE_BITS'($urandom());
         for (int k = 0; k < seq_len; k++) begin
            for (int r = 0; r < ROWS; r++) col[r] = draw_value(base);
            send_column(col, k == seq_len - 1, 1'b0, given);
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (pending_totals.size() != 0) @(posedge clock);
      // catch any stray result after the last one expected
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (miss_count == 0 && pending_totals.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Result sink: random stalls, field-by-field check against the oldest
   // expected total
   // ------------------------------------------------------------------------
   initial begin : result_sink
      int             stall;
      cost_type       got_cost;
      bit             got_flag;
      path_total_type want;
      rsp_tready = 1'b0;
      sink_left  = 0;
      sink_calm  = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = next_gap(sink_left, sink_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         got_cost = rsp_tdata[COST_BITS-1:0];
         got_flag = rsp_tuser;
         if (pending_totals.size() == 0) begin
            report_miss($sformatf("result with no sequence closed: cost %0d flag %0b",
                                  got_cost, got_flag));
         end else begin
            want = pending_totals.pop_front();
            if (got_cost !== want.min_cost) begin
               report_miss($sformatf("min_cost expected %0d got %0d",
                                     want.min_cost, got_cost));
            end
            if (got_flag !== want.saturated) begin
               report_miss($sformatf("cost_saturated expected %0b got %0b",
                                     want.saturated, got_flag));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too long with no item moving on either side ends the run
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("[%0t] watchdog: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
